// ===== sv/stg_pkg.sv =====
// ----------------------------------------------------------------------------
// stg_pkg
// Shared types and constants for the swept tone generator: register
// indexes, waveform codes, the configuration bundle and scaling constants.
// ----------------------------------------------------------------------------
package stg_pkg;

  typedef enum logic [2:0] {
    CFG_WAVEFORM    = 3'd0,
    CFG_START_STEP  = 3'd1,
    CFG_SWEEP_DELTA = 3'd2,
    CFG_RUN_LENGTH  = 3'd3,
    CFG_AMPLITUDE   = 3'd4,
    CFG_BALANCE     = 3'd5,
    CFG_PEAK_LEVEL  = 3'd6
  } cfg_index_t;

  localparam logic [1:0] WAVE_SINE   = 2'd0;
  localparam logic [1:0] WAVE_SQUARE = 2'd1;
  localparam logic [1:0] WAVE_SAW    = 2'd2;

  localparam int CFG_DATA_W = 48;

  localparam logic [6:0]        AMP_MAX     = 7'd100;
  localparam logic signed [7:0] BAL_MAX     = 8'sd100;
  localparam logic signed [7:0] BAL_MIN     = -8'sd100;
  localparam logic [6:0]        GAIN_FULL   = 7'd100;
  localparam logic [14:0]       PEAK_RESET  = 15'd32767;

  // Reciprocal of 10000 for products below 2^29: q = (y * MUL) >> SHIFT.
  localparam logic [29:0] DIV10K_MUL   = 30'd879609303;
  localparam int          DIV10K_SHIFT = 43;

  typedef struct packed {
    logic [1:0]         waveform;
    logic [47:0]        start_step;
    logic signed [47:0] sweep_delta;
    logic [31:0]        run_length;
    logic [6:0]         amp_pct;
    logic signed [7:0]  balance;
    logic [14:0]        peak_level;
  } cfg_t;

endpackage

// ===== sv/swept_tone_generator_top.sv =====
// ----------------------------------------------------------------------------
// swept_tone_generator_top
// Throughput: one sample pair per cycle when the output is not stalled; the
// front end's 48-bit phase and sweep adds set it; the back pipeline keeps pace.
// A 4-entry queue lets the front take requests while the output stalls.
// Reset (synchronous) restores the register defaults and clears the run;
// the sine table is a constant ROM, so there is no clearing pass.
// ----------------------------------------------------------------------------
module swept_tone_generator_top #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int PHASE_BITS       = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [stg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          restart,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            left_sample,
  output logic signed [15:0]            right_sample,
  output logic                          run_end
);

  import stg_pkg::*;

  cfg_t                  cfg;
  logic                  push;
  logic [PHASE_BITS-1:0] push_phase;
  logic                  push_run_end;
  logic                  queue_full;
  logic                  q_valid;
  logic                  q_pop;
  logic [PHASE_BITS:0]   q_data;
  logic signed [7:0]     bal_in;

  assign cfg_ready = 1'b1;
  assign bal_in    = cfg_data[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.waveform    <= WAVE_SINE;
      cfg.start_step  <= '0;
      cfg.sweep_delta <= '0;
      cfg.run_length  <= 32'd1;
      cfg.amp_pct     <= AMP_MAX;
      cfg.balance     <= '0;
      cfg.peak_level  <= PEAK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WAVEFORM:    cfg.waveform    <= cfg_data[1:0];
        CFG_START_STEP:  cfg.start_step  <= cfg_data[47:0];
        CFG_SWEEP_DELTA: cfg.sweep_delta <= cfg_data[47:0];
        CFG_RUN_LENGTH:  cfg.run_length  <= cfg_data[31:0];
        CFG_AMPLITUDE: begin
          cfg.amp_pct <= (cfg_data[6:0] > AMP_MAX) ? AMP_MAX : cfg_data[6:0];
        end
        CFG_BALANCE: begin
          if (bal_in > BAL_MAX) begin
            cfg.balance <= BAL_MAX;
          end else if (bal_in < BAL_MIN) begin
            cfg.balance <= BAL_MIN;
          end else begin
            cfg.balance <= bal_in;
          end
        end
        CFG_PEAK_LEVEL:  cfg.peak_level  <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  stg_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .restart      (restart),
    .push         (push),
    .push_phase   (push_phase),
    .push_run_end (push_run_end),
    .queue_full   (queue_full)
  );

  stg_fifo #(
    .WIDTH (PHASE_BITS + 1),
    .DEPTH (4)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_run_end, push_phase}),
    .full      (queue_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  stg_back #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .PHASE_BITS       (PHASE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_phase      (q_data[PHASE_BITS-1:0]),
    .q_run_end    (q_data[PHASE_BITS]),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .run_end      (run_end)
  );

endmodule

// ===== sv/stg_fifo.sv =====
// ----------------------------------------------------------------------------
// stg_fifo
// Small register queue between the phase front end and the sample pipeline.
// ----------------------------------------------------------------------------
module stg_fifo #(
  parameter int WIDTH = 49,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/stg_front.sv =====
// ----------------------------------------------------------------------------
// stg_front
// Accepts tick requests, runs the phase accumulator, the linear sweep of the
// phase step and the run counter, and queues the phase of each sample.
// ----------------------------------------------------------------------------
module stg_front #(
  parameter int PHASE_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  stg_pkg::cfg_t         cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  restart,
  output logic                  push,
  output logic [PHASE_BITS-1:0] push_phase,
  output logic                  push_run_end,
  input  logic                  queue_full
);

  import stg_pkg::*;

  logic [PHASE_BITS-1:0] phase_acc;
  logic [47:0]           sweep_offset;
  logic [31:0]           sample_index;

  logic [PHASE_BITS-1:0] cur_phase;
  logic [47:0]           cur_offset;
  logic [31:0]           cur_index;
  logic [47:0]           step_sum;
  logic [PHASE_BITS-1:0] step;
  logic                  run_done;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  // A restart clears the run state before this sample is produced.
  assign cur_phase  = restart ? '0 : phase_acc;
  assign cur_offset = restart ? '0 : sweep_offset;
  assign cur_index  = restart ? '0 : sample_index;

  assign step_sum = cfg.start_step + cur_offset;
  assign step     = step_sum[47 -: PHASE_BITS];
  assign run_done = ({1'b0, cur_index} + 33'd1) >= {1'b0, cfg.run_length};

  assign push_phase   = cur_phase;
  assign push_run_end = run_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc    <= '0;
      sweep_offset <= '0;
      sample_index <= '0;
    end else if (push) begin
      if (run_done) begin
        phase_acc    <= '0;
        sweep_offset <= '0;
        sample_index <= '0;
      end else begin
        phase_acc    <= cur_phase + step;
        sweep_offset <= cur_offset + cfg.sweep_delta;
        sample_index <= cur_index + 32'd1;
      end
    end
  end

endmodule

// ===== sv/stg_back.sv =====
// ----------------------------------------------------------------------------
// stg_back
// Sample pipeline: waveform generation from the queued phase, amplitude and
// balance scaling with truncation toward zero, and the output register.
// ----------------------------------------------------------------------------
module stg_back #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int PHASE_BITS       = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  stg_pkg::cfg_t         cfg,
  input  logic                  q_valid,
  input  logic [PHASE_BITS-1:0] q_phase,
  input  logic                  q_run_end,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    left_sample,
  output logic signed [15:0]    right_sample,
  output logic                  run_end
);

  import stg_pkg::*;

  localparam int AW    = $clog2(SINE_TABLE_DEPTH);
  localparam int LO_W  = PHASE_BITS / 2;
  localparam int HI_W  = PHASE_BITS - LO_W;
  localparam int OPA_W = (LO_W > 15) ? LO_W : 15;
  localparam int PA_W  = OPA_W + 15;
  localparam int PB_W  = HI_W + 15;
  localparam int SUM_W = PHASE_BITS + 16;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [15:0] rom_t [SINE_TABLE_DEPTH];

  // Q15 sine of one table entry, from an integer Taylor series in Q30.
  function automatic logic signed [15:0] sine_entry(input int k);
    logic [63:0] p;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] q;
    logic [1:0]  quad;
    p    = (64'(k) << 32) / SINE_TABLE_DEPTH;
    quad = p[31:30];
    r    = {34'd0, p[29:0]};
    if (quad[0]) begin
      r = 64'h4000_0000 - r;
    end
    x    = (r * HALF_PI_Q30) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 6; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    q = (sum + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return quad[1] ? -16'(q) : 16'(q);
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      t[k] = sine_entry(k);
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic en;

  // stage 1: queued phase
  logic                  s1_valid;
  logic                  s1_run_end;
  logic [PHASE_BITS-1:0] s1_phase;
  logic [AW-1:0]         rom_idx;
  logic [PHASE_BITS-1:0] half_turn;
  logic [PHASE_BITS-1:0] saw_m;

  // stage 2: table entry and sawtooth magnitude
  logic                  s2_valid;
  logic                  s2_run_end;
  logic                  s2_msb;
  logic signed [15:0]    rom_q;
  logic [PHASE_BITS-1:0] s2_m;
  logic                  e_neg;
  logic [15:0]           e_abs;
  logic [OPA_W-1:0]      opa;
  logic [LO_W-1:0]       m_lo;
  logic [HI_W-1:0]       m_hi;
  logic                  s2_neg;

  // stage 3: products
  logic                  s3_valid;
  logic                  s3_run_end;
  logic                  s3_neg;
  logic [PA_W-1:0]       prod_a;
  logic [PB_W-1:0]       prod_b;
  logic [29:0]           sine_x;
  logic [30:0]           sine_sum;
  logic [SUM_W-1:0]      saw_sum;
  logic [14:0]           mag;

  // stage 4: waveform sample magnitude
  logic                  s4_valid;
  logic                  s4_run_end;
  logic                  s4_neg;
  logic [14:0]           s4_mag;
  logic [6:0]            gain_l;
  logic [6:0]            gain_r;
  logic [13:0]           ag_l;
  logic [13:0]           ag_r;

  // stage 5: scaled products
  logic                  s5_valid;
  logic                  s5_run_end;
  logic                  s5_neg;
  logic [28:0]           y_l;
  logic [28:0]           y_r;

  // stage 6: reciprocal products
  logic                  s6_valid;
  logic                  s6_run_end;
  logic                  s6_neg;
  logic [58:0]           z_l;
  logic [58:0]           z_r;
  logic [15:0]           q_l;
  logic [15:0]           q_r;

  // The whole pipeline moves together unless the output holds a result.
  assign en    = !out_valid || out_ready;
  assign q_pop = en;

  assign rom_idx   = s1_phase[PHASE_BITS-1 -: AW];
  assign half_turn = {1'b1, {(PHASE_BITS-1){1'b0}}};
  // Sawtooth magnitude is |2p - 2^N| / 2, i.e. the distance from half a turn.
  assign saw_m     = s1_phase[PHASE_BITS-1] ? (s1_phase - half_turn)
                                            : (half_turn - s1_phase);

  assign e_neg = rom_q[15];
  assign e_abs = e_neg ? (16'd0 - rom_q) : rom_q;
  assign m_lo  = s2_m[LO_W-1:0];
  assign m_hi  = s2_m[PHASE_BITS-1:LO_W];
  assign opa   = (cfg.waveform == WAVE_SINE) ? OPA_W'(e_abs[14:0]) : OPA_W'(m_lo);

  always_comb begin
    unique case (cfg.waveform)
      WAVE_SINE:   s2_neg = e_neg;
      WAVE_SQUARE: s2_neg = s2_msb;
      WAVE_SAW:    s2_neg = !s2_msb;
      default:     s2_neg = 1'b0;
    endcase
  end

  // Division by 32767 of a value below 2^30: (x + (x >> 15) + 1) >> 15.
  assign sine_x   = prod_a[29:0];
  assign sine_sum = {1'b0, sine_x} + 31'(sine_x >> 15) + 31'd1;
  assign saw_sum  = (SUM_W'(prod_b) << LO_W) + SUM_W'(prod_a);

  always_comb begin
    unique case (cfg.waveform)
      WAVE_SINE:   mag = sine_sum[29:15];
      WAVE_SQUARE: mag = cfg.peak_level;
      WAVE_SAW:    mag = saw_sum[PHASE_BITS-1 +: 15];
      default:     mag = '0;
    endcase
  end

  assign gain_l = (cfg.balance > 8'sd0) ? 7'(8'd100 - cfg.balance) : GAIN_FULL;
  assign gain_r = (cfg.balance < 8'sd0) ? 7'(8'd100 + cfg.balance) : GAIN_FULL;

  assign q_l = {1'b0, z_l[DIV10K_SHIFT +: 15]};
  assign q_r = {1'b0, z_r[DIV10K_SHIFT +: 15]};

  // Gain products follow the registers; the user must change those only while idle (not enforced here).
  always_ff @(posedge clk) begin
    ag_l <= cfg.amp_pct * gain_l;
    ag_r <= cfg.amp_pct * gain_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_phase   <= q_phase;
      s1_run_end <= q_run_end;
      rom_q      <= SINE_ROM[rom_idx];
      s2_m       <= saw_m;
      s2_msb     <= s1_phase[PHASE_BITS-1];
      s2_run_end <= s1_run_end;
      prod_a     <= opa * cfg.peak_level;
      prod_b     <= m_hi * cfg.peak_level;
      s3_neg     <= s2_neg;
      s3_run_end <= s2_run_end;
      s4_mag     <= mag;
      s4_neg     <= s3_neg;
      s4_run_end <= s3_run_end;
      y_l        <= s4_mag * ag_l;
      y_r        <= s4_mag * ag_r;
      s5_neg     <= s4_neg;
      s5_run_end <= s4_run_end;
      z_l        <= y_l * DIV10K_MUL;
      z_r        <= y_r * DIV10K_MUL;
      s6_neg     <= s5_neg;
      s6_run_end <= s5_run_end;
      left_sample  <= s6_neg ? (16'd0 - q_l) : q_l;
      right_sample <= s6_neg ? (16'd0 - q_r) : q_r;
      run_end      <= s6_run_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      s6_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= q_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      s6_valid  <= s5_valid;
      out_valid <= s6_valid;
    end
  end

endmodule

// ===== sv/stg_checker.sv =====
// ----------------------------------------------------------------------------
// stg_checker
// Port-level checks of the tone generator: output hold under stall, quiet
// after reset, and request accounting against delivered samples.
// ----------------------------------------------------------------------------
module stg_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] left_sample,
  input logic signed [15:0] right_sample,
  input logic               run_end
);

  logic [4:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Requests accepted whose sample pair has not been taken yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 5'd1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 5'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_sample)
      && $stable(right_sample) && $stable(run_end))
    else $error("output changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 5'd0)
    else $error("sample shown without an outstanding request");

  a_stall_has_work: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> pending != 5'd0)
    else $error("input stalled with nothing in flight");

endmodule

bind swept_tone_generator_top stg_checker u_stg_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .left_sample  (left_sample),
  .right_sample (right_sample),
  .run_end      (run_end)
);
